// ===== hdl/newton_sqrt_approx_macros.svh =====
// ----------------------------------------------------------------------------
// newton_sqrt_approx_macros - assertion macros
// Shared concurrent assertion forms for the square-root block.
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQRT_APPROX_MACROS_SVH
`define NEWTON_SQRT_APPROX_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("newton_sqrt_approx: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define NSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("newton_sqrt_approx: next-cycle check failed");

`endif

// ===== hdl/nsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nsa_pkg
// Widths and constants for the Newton square-root approximator.
// ----------------------------------------------------------------------------
package nsa_pkg;

   localparam int FRAC_BITS     = 16;   // fraction bits of the estimate, 8..32
   localparam int RADICAND_BITS = 32;   // radicand bits used, 8..48

   localparam int RADICAND_W = 32;      // port widths
   localparam int ITER_W     = 6;
   localparam int ROOT_W     = 48;

   // guess register, numerator of N << 2F, and bit counter for the divider
   localparam int GUESS_W = RADICAND_BITS + FRAC_BITS;
   localparam int NUM_W   = RADICAND_BITS + 2 * FRAC_BITS;
   localparam int CNT_W   = $clog2(NUM_W);

endpackage

// ===== hdl/newton_sqrt_approx.sv =====
// ----------------------------------------------------------------------------
// newton_sqrt_approx
// Newton-Raphson square root with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Use:
//   A request transfer happens at a rising edge with start high and busy low;
//   it carries req_radicand (only the low RADICAND_BITS bits count) and
//   req_iteration_count. busy stays high while the block iterates.
//   Each request yields one response: rsp_valid is high for exactly one cycle
//   with rsp_root_estimate (unsigned, FRAC_BITS fraction bits) and
//   rsp_zero_input. The receiver cannot stall; rsp_valid drops after that cycle,
//   while rsp_root_estimate and rsp_zero_input hold until the next response.
// Operation:
//   The guess starts at N/2. Each refinement step is one quotient bit per
//   cycle through the divider shift registers (NUM_W bits, 64 by default),
//   then the S_UPD state does the add and halving of the guess.
//   The block runs as many steps as the iteration count asks, fewer if a
//   guess comes to zero; a zero radicand or a zero count answers from idle.
//   Throughput is one request per response; a new request may be taken in
//   the cycle the previous response is shown.
// Reset:
//   Synchronous, active high: returns to idle and drops rsp_valid. Any
//   request under way is lost.
// ----------------------------------------------------------------------------
`include "newton_sqrt_approx_macros.svh"

module newton_sqrt_approx
   import nsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [RADICAND_W-1:0] req_radicand,
   input  logic [ITER_W-1:0]     req_iteration_count,
   output logic                  rsp_valid,
   output logic [ROOT_W-1:0]     rsp_root_estimate,
   output logic                  rsp_zero_input
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_UPD
   } state_type;

   state_type              state_ff, state_in;
   logic [RADICAND_BITS-1:0] n_ff, n_in;        // radicand, kept for each reload
   logic [ITER_W-1:0]      iter_ff, iter_in;    // steps still to do
   logic [GUESS_W-1:0]     x_ff, x_in;          // current guess = divisor
   logic [NUM_W-1:0]       num_ff, num_in;      // numerator, shifted out MSB first
   logic [NUM_W-1:0]       q_ff, q_in;          // quotient, shifted in LSB
   logic [GUESS_W-1:0]     rem_ff, rem_in;      // partial remainder, always < x
   logic [CNT_W-1:0]       cnt_ff, cnt_in;      // quotient bits left after the current one
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]      rsp_root_ff, rsp_root_in;
   logic                   rsp_zero_ff, rsp_zero_in;

   logic                     accept;
   logic [RADICAND_BITS-1:0] n_req;
   logic [GUESS_W-1:0]       x_init;
   logic [NUM_W-1:0]         num_init;
   logic [GUESS_W:0]         rem_shift;
   logic [GUESS_W:0]         rem_diff;
   logic                     q_bit;
   logic [NUM_W:0]           guess_sum;
   logic [GUESS_W-1:0]       x_next;

   assign accept    = start && (state_ff == S_IDLE);
   assign n_req     = RADICAND_BITS'(req_radicand);
   // (N << F) >> 1
   assign x_init    = {n_req, {FRAC_BITS{1'b0}}} >> 1;
   assign num_init  = {n_ff, {(2 * FRAC_BITS){1'b0}}};

   // restoring divider: one quotient bit a cycle
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit     = rem_shift >= {1'b0, x_ff};
   assign rem_diff  = rem_shift - {1'b0, x_ff};

   // (x + q) / 2; the guess never leaves GUESS_W bits
   assign guess_sum = (NUM_W + 1)'(q_ff) + (NUM_W + 1)'(x_ff);
   assign x_next    = guess_sum[GUESS_W:1];

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      iter_in      = iter_ff;
      x_in         = x_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in  = rsp_root_ff;
      rsp_zero_in  = rsp_zero_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in    = n_req;
               iter_in = req_iteration_count;
               x_in    = x_init;
               if (n_req == '0) begin
                  // zero radicand: no division, flag it
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = '0;
                  rsp_zero_in  = 1'b1;
               end else if (req_iteration_count == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = ROOT_W'(x_init);
                  rsp_zero_in  = 1'b0;
               end else begin
                  num_in   = {n_req, {(2 * FRAC_BITS){1'b0}}};
                  rem_in   = '0;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            num_in = num_ff << 1;
            q_in   = {q_ff[NUM_W-2:0], q_bit};
            rem_in = q_bit ? rem_diff[GUESS_W-1:0] : rem_shift[GUESS_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            x_in    = x_next;
            iter_in = iter_ff - ITER_W'(1);
            // a zero guess would end the refinement with the guess kept
            if ((iter_ff == ITER_W'(1)) || (x_next == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = ROOT_W'(x_next);
               rsp_zero_in  = 1'b0;
               state_in     = S_IDLE;
            end else begin
               num_in   = num_init;
               rem_in   = '0;
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = S_DIV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      iter_ff     <= iter_in;
      x_ff        <= x_in;
      num_ff      <= num_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_root_ff <= rsp_root_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root_estimate = rsp_root_ff;
   assign rsp_zero_input    = rsp_zero_ff;

   // divisor is never zero while dividing, and the remainder stays below it
   `NSA_ASSERT_SAME(a_div_nonzero, clock, reset, state_ff == S_DIV, x_ff != '0)
   `NSA_ASSERT_SAME(a_rem_below, clock, reset, state_ff == S_DIV, rem_ff < x_ff)
   // zero radicand answers at once, flagged
   `NSA_ASSERT_NEXT(a_zero_fast, clock, reset, accept && (n_req == '0),
      rsp_valid && rsp_zero_input && (rsp_root_estimate == '0))
   // a response only follows a finishing step or an immediate answer
   `NSA_ASSERT_SAME(a_rsp_source, clock, reset, rsp_valid,
      $past(state_ff == S_UPD) || $past(accept))

endmodule
